@@ sv/dblr_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-buffered line receiver package
// Shared types, command codes, register indexes and constants.
// ----------------------------------------------------------------------------
package dblr_pkg;

  // Default depth of each line buffer in bytes.
  localparam int BUF_DEPTH_DEF = 64;

  // Line terminator.
  localparam logic [7:0] NEWLINE = 8'h0A;

  // Configuration register indexes and reset values.
  localparam logic CFG_TIMEOUT_ENABLE = 1'b0;
  localparam logic CFG_IDLE_LIMIT     = 1'b1;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd100;
  localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_READ  = 2'd3
  } dblr_cmd_t;

  typedef struct packed {
    dblr_cmd_t   command;
    logic [7:0]  rx_byte;
    logic [5:0]  read_index;
  } dblr_in_t;

  typedef struct packed {
    logic [5:0]  line_length;
    logic [7:0]  char_out;
    logic        line_ready;
    logic        overflow;
  } dblr_out_t;

  typedef struct packed {
    logic        timeout_enable;
    logic [15:0] idle_limit;
  } dblr_cfg_t;

  // Result fields known at the accepting edge; the byte comes from the store.
  typedef struct packed {
    logic [5:0]  line_length;
    logic        line_ready;
    logic        overflow;
    logic        rd_hit;
  } dblr_s1_t;

endpackage

@@ sv/dblr_store.sv @@
// ----------------------------------------------------------------------------
// Line store
// Two line buffers in one memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dblr_store #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(BUF_DEPTH):0]   wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(BUF_DEPTH):0]   rd_addr,
  output logic [7:0]                   rd_data
);
  localparam int AW = $clog2(BUF_DEPTH) + 1;

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/dblr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Line receiver control
// Fill counters, buffer swap, ready and overflow flags, and the idle timer.
// ----------------------------------------------------------------------------
module dblr_ctrl #(
  parameter int BUF_DEPTH = dblr_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  dblr_pkg::dblr_in_t           in_item,
  input  dblr_pkg::dblr_cfg_t          cfg,
  output logic                         wr_en,
  output logic [$clog2(BUF_DEPTH):0]   wr_addr,
  output logic [7:0]                   wr_data,
  output logic [$clog2(BUF_DEPTH):0]   rd_addr,
  output dblr_pkg::dblr_s1_t           s1
);
  import dblr_pkg::*;

  localparam int CW = $clog2(BUF_DEPTH);
  localparam int LW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] FILL_LIMIT = CW'(BUF_DEPTH - 1);

  logic [CW-1:0] fill_r   [2];
  logic [CW-1:0] fill_nxt [2];
  logic          active_r, active_nxt;
  logic [CW-1:0] rlen_r, rlen_nxt;
  logic          ready_r, ready_nxt;
  logic          ovf_r, ovf_nxt;
  logic          armed_r, armed_nxt;
  logic [15:0]   idle_r, idle_nxt;

  always_comb begin
    logic          a;
    logic [CW-1:0] f;
    logic [LW-1:0] len_ext;
    a          = active_r;
    f          = fill_r[active_r];
    fill_nxt   = fill_r;
    active_nxt = active_r;
    rlen_nxt   = rlen_r;
    ready_nxt  = ready_r;
    ovf_nxt    = ovf_r;
    armed_nxt  = armed_r;
    idle_nxt   = idle_r;
    wr_en      = 1'b0;
    wr_data    = in_item.rx_byte;
    case (in_item.command)
      CMD_BYTE: begin
        // An open line that sat idle too long is thrown away first.
        if (cfg.timeout_enable && armed_r && (idle_r >= cfg.idle_limit)) begin
          ovf_nxt = 1'b1;
          f       = '0;
        end
        armed_nxt = 1'b1;
        idle_nxt  = '0;
        if (f < FILL_LIMIT) begin
          wr_en       = take;
          fill_nxt[a] = f + 1'b1;
          if (in_item.rx_byte == NEWLINE) begin
            ready_nxt    = 1'b1;
            rlen_nxt     = f + 1'b1;
            active_nxt   = ~a;
            fill_nxt[~a] = '0;
            armed_nxt    = 1'b0;
          end
        end else begin
          ovf_nxt     = 1'b1;
          fill_nxt[a] = '0;
          armed_nxt   = 1'b0;
        end
      end
      CMD_TICK: begin
        if (armed_r && (idle_r != IDLE_MAX)) begin
          idle_nxt = idle_r + 16'd1;
        end
      end
      CMD_FETCH: begin
        ovf_nxt   = 1'b0;
        ready_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    wr_addr = {a, f};
    rd_addr = {~active_r, CW'(in_item.read_index)};

    len_ext        = LW'(rlen_nxt);
    s1.line_length = ((in_item.command == CMD_FETCH) && ovf_r) ? 6'd0 : len_ext[5:0];
    s1.line_ready  = ready_nxt;
    s1.overflow    = ovf_nxt;
    s1.rd_hit      = (in_item.command == CMD_READ) &&
                     (LW'(in_item.read_index) < LW'(rlen_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      active_r  <= 1'b0;
      rlen_r    <= '0;
      ready_r   <= 1'b0;
      ovf_r     <= 1'b0;
      armed_r   <= 1'b0;
      idle_r    <= '0;
    end else if (take) begin
      fill_r    <= fill_nxt;
      active_r  <= active_nxt;
      rlen_r    <= rlen_nxt;
      ready_r   <= ready_nxt;
      ovf_r     <= ovf_nxt;
      armed_r   <= armed_nxt;
      idle_r    <= idle_nxt;
    end
  end

endmodule

@@ sv/double_buffered_line_receiver.sv @@
// ----------------------------------------------------------------------------
// Double-buffered line receiver
// Collects received bytes into two ping-pong line buffers.
// ----------------------------------------------------------------------------
// Usage: every input transfer carries one command: a received byte, a
// millisecond tick, a fetch of the completed line or a read of one of its
// bytes. Every input transfer produces exactly one output transfer with the
// latched line length, the byte read (zero unless a read hits the line) and
// the ready and overflow flags as they stand after the command.
// A result passes the middle stage and the output register. One item can
// be accepted every cycle while the output side does not stall: the control
// state is updated at the accepting edge and the store read is registered in
// the same edge. The store has a separate write port and read port, each used
// at most once per item. When the receiver stalls, a finished result waits
// in the output register and one more item is still taken into the middle
// stage; only then does in_ready drop.
// Reset (synchronous, active low) clears flags, fill counts and the timer,
// and sets the timeout enable to 0 and the idle limit to 100. The line store
// is not cleared; a read only reaches bytes of a line that was completed.
// Configuration writes take effect at the edge where cfg_wr_en is high.
// ----------------------------------------------------------------------------
module double_buffered_line_receiver #(
  parameter int BUF_DEPTH = dblr_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dblr_pkg::dblr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dblr_pkg::dblr_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import dblr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH) + 1;

  dblr_cfg_t  cfg_r;
  dblr_s1_t   s1_nxt, s1_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  dblr_out_t  out_data_r;
  logic       out_en;
  logic       take;
  logic       wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0] wr_data, rd_data;

  // The output register loads when it is empty or its transfer completes now.
  assign out_en   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_en;
  assign take     = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_enable <= 1'b0;
      cfg_r.idle_limit     <= IDLE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TIMEOUT_ENABLE: cfg_r.timeout_enable <= cfg_wdata[0];
        CFG_IDLE_LIMIT:     cfg_r.idle_limit     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dblr_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_item (in_data),
    .cfg     (cfg_r),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .s1      (s1_nxt)
  );

  // The read data register holds while the middle stage is stalled, since
  // it only loads on an accepted item.
  dblr_store #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Middle stage: result fields known at acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (out_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_data_r.line_length <= s1_r.line_length;
      out_data_r.char_out    <= s1_r.rd_hit ? rd_data : 8'd0;
      out_data_r.line_ready  <= s1_r.line_ready;
      out_data_r.overflow    <= s1_r.overflow;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/dblr_checker.sv @@
// ----------------------------------------------------------------------------
// Line receiver port checker
// Watches the top-level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module dblr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dblr_pkg::dblr_out_t out_data
);
  import dblr_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output result changed or vanished while stalled");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The input side only backs up when the output side is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled output");

  // An item taken while no result is offered comes out through the middle stage and the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing two cycles after transfer");

endmodule

bind double_buffered_line_receiver dblr_checker u_dblr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/line_receiver_checker.sv @@
// ----------------------------------------------------------------------------
// Line receiver checker
// Watches the command, result and register channels of the double-buffered
// line receiver. It keeps its own copy of the line buffers, flags, timer and
// registers, works out the result of every accepted command, and compares
// each accepted result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module line_receiver_checker #(
  parameter int BUF_DEPTH = dblr_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dblr_pkg::dblr_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dblr_pkg::dblr_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending_count
);
  import dblr_pkg::*;

  logic [7:0]  line_mem [2][BUF_DEPTH];
  int unsigned fill_level [2];
  logic        fill_sel;
  int unsigned done_len;
  logic        ready_q;
  logic        ovf_q;
  logic        armed_q;
  logic [15:0] idle_ticks;
  logic        to_enable;
  logic [15:0] to_limit;

  dblr_out_t   awaited [$];
  int          fails = 0;
  int          npend = 0;

  assign fail_count    = fails;
  assign pending_count = npend;

  // Applies one command to the shadow state and returns the result it gives.
  function automatic dblr_out_t line_response(dblr_in_t item);
    dblr_out_t   r;
    int unsigned len_out;
    logic        sel;
    r       = '0;
    len_out = done_len;
    sel     = fill_sel;
    case (item.command)
      CMD_BYTE: begin
        if (to_enable && armed_q && idle_ticks >= to_limit) begin
          ovf_q           = 1'b1;
          fill_level[sel] = 0;
        end
        armed_q    = 1'b1;
        idle_ticks = '0;
        if (fill_level[sel] < BUF_DEPTH - 1) begin
          line_mem[sel][fill_level[sel]] = item.rx_byte;
          fill_level[sel]++;
          if (item.rx_byte == NEWLINE) begin
            ready_q          = 1'b1;
            done_len         = fill_level[sel];
            fill_sel         = ~sel;
            fill_level[~sel] = 0;
            armed_q          = 1'b0;
          end
        end else begin
          // No room left: the byte is lost together with the whole line.
          ovf_q           = 1'b1;
          fill_level[sel] = 0;
          armed_q         = 1'b0;
        end
        len_out = done_len;
      end
      CMD_TICK: begin
        if (armed_q && idle_ticks != IDLE_MAX) idle_ticks++;
      end
      CMD_FETCH: begin
        if (ovf_q) begin
          ovf_q   = 1'b0;
          len_out = 0;
        end
        ready_q = 1'b0;
      end
      default: begin
        if (item.read_index < done_len && item.read_index < BUF_DEPTH)
          r.char_out = line_mem[~fill_sel][item.read_index];
      end
    endcase
    r.line_length = 6'(len_out);
    r.line_ready  = ready_q;
    r.overflow    = ovf_q;
    return r;
  endfunction

  task automatic report(string msg);
    fails++;
    if (fails <= 10) $display("%0t: result mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    dblr_out_t want;
    if (!rst_n) begin
      fill_level[0] = 0;
      fill_level[1] = 0;
      fill_sel      = 1'b0;
      done_len      = 0;
      ready_q       = 1'b0;
      ovf_q         = 1'b0;
      armed_q       = 1'b0;
      idle_ticks    = '0;
      to_enable     = 1'b0;
      to_limit      = IDLE_LIMIT_RST;
      awaited.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_TIMEOUT_ENABLE) to_enable = cfg_wdata[0];
        else to_limit = cfg_wdata;
      end
      if (in_valid && in_ready) awaited.push_back(line_response(in_data));
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          report($sformatf("unexpected result length %0d char %02h ready %b overflow %b",
                           out_data.line_length, out_data.char_out,
                           out_data.line_ready, out_data.overflow));
        end else begin
          want = awaited.pop_front();
          if (out_data.line_length !== want.line_length ||
              out_data.char_out !== want.char_out ||
              out_data.line_ready !== want.line_ready ||
              out_data.overflow !== want.overflow)
            report($sformatf({"expected length %0d char %02h ready %b overflow %b, ",
                              "got length %0d char %02h ready %b overflow %b"},
                             want.line_length, want.char_out, want.line_ready,
                             want.overflow, out_data.line_length, out_data.char_out,
                             out_data.line_ready, out_data.overflow));
        end
      end
    end
    npend = awaited.size();
  end

endmodule

@@ test/tb_double_buffered_line_receiver.sv @@
// ----------------------------------------------------------------------------
// Double-buffered line receiver testbench
// Drives received bytes, millisecond ticks, line fetches and byte reads into
// the receiver under several timeout settings, with random gaps on both
// channels, a long result hold-off and tick bursts around the idle limit.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_double_buffered_line_receiver;
  import dblr_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT     = 22;
  // The result side holds off this long once, which is the longest correct
  // stretch without any transfer; the watchdog limit is well above it.
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  dblr_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  dblr_out_t   out_data;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending_count;

  // Random gaps on both sides are switched off as a whole for one phase.
  bit          idle_on = 1'b1;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit          hold_out = 1'b0;
  // Timeout limit currently programmed, used to size tick bursts.
  logic [15:0] cur_ms = IDLE_LIMIT_RST;
  int unsigned items_sent = 0;
  int          quiet_cycles = 0;

  always #(HALF_PERIOD) clk = ~clk;

  double_buffered_line_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  line_receiver_checker #(
    .BUF_DEPTH (BUF_DEPTH_DEF)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // One command transfer. Inputs change only at the falling edge; in_ready is
  // looked at on the rising edge, where the transfer actually happens. On
  // return the clock is at a falling edge and in_valid is still high, so a
  // following command keeps valid up without a glitch.
  task automatic send(dblr_cmd_t cmd, logic [7:0] data_byte, logic [5:0] idx);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, rx_byte: data_byte, read_index: idx};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Stops offering commands and waits until every awaited result has left.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Registers are only written with the block empty. The enable write carries
  // random upper bits, which the block must ignore.
  task automatic set_timeout(logic enable, logic [15:0] limit_ms);
    settle();
    write_reg(CFG_TIMEOUT_ENABLE, {15'($urandom), enable});
    write_reg(CFG_IDLE_LIMIT, limit_ms);
    cur_ms = limit_ms;
  endtask

  // Mostly text without a newline; now and then a stray newline splits a line.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == NEWLINE && $urandom_range(99) < 97) b = b ^ 8'h40;
    return b;
  endfunction

  // Line bodies are mostly short; a few come close to the buffer size or run
  // past it, which makes the receiver drop the line.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 80) return $urandom_range(16, 1);
    if (r < 93) return $urandom_range(58, 17);
    return $urandom_range(70, 59);
  endfunction

  // A well-formed exchange: a line of text with ticks in between, its
  // newline, then usually a fetch and a few reads of the finished line.
  task automatic send_line(int unsigned body_len, int unsigned tick_pct);
    int unsigned n_ticks;
    int unsigned n_reads;
    int unsigned top_idx;
    for (int unsigned k = 0; k < body_len; k++) begin
      if ($urandom_range(99) < tick_pct)
        send(CMD_TICK, 8'($urandom_range(255)), 6'($urandom_range(63)));
      // With a short limit, a burst right around the limit lands on both
      // sides of the timeout comparison.
      if (cur_ms <= 8 && $urandom_range(99) < 4) begin
        n_ticks = cur_ms + $urandom_range(2);
        if (n_ticks > 0) n_ticks--;
        repeat (n_ticks) send(CMD_TICK, 8'($urandom_range(255)), 6'($urandom_range(63)));
      end
      send(CMD_BYTE, text_byte(), 6'($urandom_range(63)));
    end
    send(CMD_BYTE, NEWLINE, 6'($urandom_range(63)));
    top_idx = (body_len + 2 > 63) ? 63 : body_len + 2;
    if ($urandom_range(99) < 20)
      send(CMD_READ, 8'($urandom_range(255)), 6'($urandom_range(top_idx)));
    if ($urandom_range(99) < 75)
      send(CMD_FETCH, 8'($urandom_range(255)), 6'($urandom_range(63)));
    n_reads = $urandom_range(3);
    repeat (n_reads) send(CMD_READ, 8'($urandom_range(255)), 6'($urandom_range(top_idx)));
  endtask

  // Mostly whole lines, with short runs of arbitrary commands as noise.
  task automatic run_traffic(int unsigned count, int unsigned tick_pct);
    int unsigned start;
    int unsigned burst;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 12) begin
        burst = $urandom_range(6, 1);
        repeat (burst)
          send(dblr_cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
               6'($urandom_range(63)));
      end else begin
        send_line(pick_len(), tick_pct);
      end
    end
  endtask

  // Result side: random back-pressure, one long hold-off on request, and
  // always ready while gaps are switched off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      out_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  // Watchdog: too many cycles in a row without any transfer end the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_TIMEOUT_ENABLE;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with the reset settings (timeout off, limit 100).
    // Nothing has been completed yet, so a read finds an empty line and a
    // fetch without a ready line returns the stale length.
    send(CMD_READ,  8'h00,   6'd0);
    send(CMD_FETCH, 8'h00,   6'd0);
    send(CMD_TICK,  8'hFF,   6'd63);
    // A line with the extreme byte values and ticks while it is open; the
    // counter runs but the timeout is off.
    send(CMD_BYTE,  8'h00,   6'd63);
    send(CMD_BYTE,  8'hFF,   6'd0);
    send(CMD_TICK,  8'h00,   6'd0);
    send(CMD_TICK,  8'h00,   6'd0);
    send(CMD_BYTE,  NEWLINE, 6'd0);
    // Reads inside the line, at its newline, past its end and at the top index.
    send(CMD_READ,  8'h00,   6'd0);
    send(CMD_READ,  8'h00,   6'd1);
    send(CMD_READ,  8'h00,   6'd2);
    send(CMD_READ,  8'h00,   6'd3);
    send(CMD_READ,  8'hFF,   6'd63);
    // The next line fills the other buffer while the finished one stays readable.
    send(CMD_BYTE,  8'h41,   6'd0);
    send(CMD_READ,  8'h00,   6'd1);
    send(CMD_FETCH, 8'h00,   6'd0);
    // A read with ready already cleared still sees the last finished line.
    send(CMD_READ,  8'h00,   6'd2);
    send(CMD_BYTE,  NEWLINE, 6'd0);
    send(CMD_READ,  8'h00,   6'd0);
    send(CMD_FETCH, 8'h00,   6'd0);

    // Random part. First one line one byte too long, which is dropped, and
    // then one that fills the buffer exactly.
    send_line(63, 0);
    send_line(62, 0);
    run_traffic(250, 15);

    // Short timeout. Part way through, the result side holds off while
    // commands keep coming, so the block fills up and stalls its input.
    set_timeout(1'b1, 16'd3);
    run_traffic(100, 25);
    hold_out = 1'b1;
    run_traffic(150, 25);

    // Zero limit: every byte after the first in an open line times out.
    // This phase also runs without any gaps on either side.
    set_timeout(1'b1, 16'd0);
    idle_on = 1'b0;
    run_traffic(150, 10);
    idle_on = 1'b1;

    set_timeout(1'b1, 16'd1);
    run_traffic(150, 30);

    // A longer limit: a byte after a few more ticks than the limit is seen
    // as timed out, so the open line is lost.
    set_timeout(1'b1, 16'd40);
    send(CMD_BYTE, text_byte(), 6'd0);
    send(CMD_BYTE, text_byte(), 6'd0);
    repeat (45)
      send(CMD_TICK, 8'($urandom_range(255)), 6'($urandom_range(63)));
    send(CMD_BYTE,  text_byte(), 6'd0);
    send(CMD_BYTE,  NEWLINE,     6'd0);
    send(CMD_FETCH, 8'h00,       6'd0);
    send(CMD_READ,  8'h00,       6'd0);
    send(CMD_READ,  8'h00,       6'd1);
    run_traffic(50, 20);

    // Timeout off again with a small limit: ticks pile up without effect.
    set_timeout(1'b0, 16'd2);
    run_traffic(150, 40);

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/dblr_pkg.sv
sv/dblr_store.sv
sv/dblr_ctrl.sv
sv/double_buffered_line_receiver.sv
sv/dblr_checker.sv
test/line_receiver_checker.sv
test/tb_double_buffered_line_receiver.sv
